### design/assert_macros.svh
// Assertion macros shared by the vertex transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Implication or plain property, checked on every rising edge outside reset.
`define VT4_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vt4 assertion failed");
// Condition that must never be true outside reset.
`define VT4_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("vt4 forbidden condition seen");
`else
`define VT4_ASSERT(lbl, clk, rst_n, prop)
`define VT4_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### design/vt4_pkg.sv
// Shared types and constants for the vertex transform block.
package vt4_pkg;

    localparam int NUM_LANES = 4;
    localparam int NUM_PAIRS = 8;
    localparam int CFG_IDX_W = 4;
    localparam int PROD_W    = 64;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;

    typedef enum logic [1:0] {
        CMD_FULL  = 2'd0,
        CMD_DIR   = 2'd1,
        CMD_POINT = 2'd2
    } cmd_t;

    typedef logic [3:0][31:0] vec4_t;

    // Load strobes of the three arithmetic stages.
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } pipe_ctl_t;

endpackage

### design/vt4_lane.sv
// One row lane: four products, pair sums and the exact row total.
module vt4_lane
    import vt4_pkg::*;
(
    input  logic                    clk,
    input  pipe_ctl_t               ctl,
    input  vec4_t                   row_entries,
    input  vec4_t                   vec,
    output logic signed [SUM_W-1:0] sum
);

    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [PROD_W-1:0] prod_next [4];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [PAIR_W-1:0] pair_next [2];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            prod_next[c] = PROD_W'($signed(row_entries[c]) * $signed(vec[c]));
        end
        pair_next[0] = PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
        pair_next[1] = PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        sum_next     = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load1)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_reg[c] <= prod_next[c];
            end
        end
        if (ctl.load2)
        begin
            pair_reg[0] <= pair_next[0];
            pair_reg[1] <= pair_next[1];
        end
        if (ctl.load3)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

### design/vt4_merge.sv
// Output stage: scales and clamps the four lane totals into one result word.
module vt4_merge
    import vt4_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    load,
    input  logic signed [SUM_W-1:0] lane_sum [NUM_LANES],
    output vec4_t                   result,
    output logic                    saturated
);

    vec4_t result_reg;
    vec4_t result_next;
    logic  sat_reg;
    logic  sat_next;

    logic signed [SUM_W-1:0] shifted [NUM_LANES];
    logic [NUM_LANES-1:0]    fits;

    // An arithmetic right shift of the exact sum is the floor division.
    always_comb
    begin
        sat_next = 1'b0;
        for (int r = 0; r < NUM_LANES; r++)
        begin
            shifted[r] = lane_sum[r] >>> FRAC_BITS;
            fits[r]    = (&shifted[r][SUM_W-1:31]) | ~(|shifted[r][SUM_W-1:31]);
            if (fits[r])
            begin
                result_next[r] = shifted[r][31:0];
            end
            else if (shifted[r][SUM_W-1])
            begin
                result_next[r] = 32'h8000_0000;
            end
            else
            begin
                result_next[r] = 32'h7FFF_FFFF;
            end
            sat_next = sat_next | ~fits[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign result    = result_reg;
    assign saturated = sat_reg;

endmodule

### design/vertex_transform_4x4_unit.sv
// Top level of the streaming 4x4 fixed-point vertex transform.
//
// Usage: vectors enter on the in_valid/in_ready channel with a mode in cmd
// (full vector, direction with w = 0, point with w = 1.0). Each word leaves on
// the out_valid/out_ready channel as four signed fixed-point components, each
// the dot product of one matrix row with the vector, clamped to 32 bits, and
// a flag that is set when any component was clamped.
// The matrix lives in eight 64-bit registers written through cfg_valid,
// cfg_ready, cfg_index and cfg_data; cfg_ready is always high and an index of
// eight or more is ignored. Writes are meant for idle periods only.
// The pipeline has four register stages: one for the multipliers, two for the
// adder tree of each row lane, one for scaling and clamping in the output register.
// out_valid rises once a word has passed the product, pair and sum registers.
// Throughput is one word per cycle while the receiver does not stall, set by
// the four row lanes of four multipliers each working side by side.
// When the receiver stalls, words close up behind the output register and
// in_ready falls only once all four stages hold a word.
// Reset empties the pipeline and loads the identity matrix.
`include "assert_macros.svh"

module vertex_transform_4x4_unit
    import vt4_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic signed [31:0]   in_x,
    input  logic signed [31:0]   in_y,
    input  logic signed [31:0]   in_z,
    input  logic signed [31:0]   in_w,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   out_x,
    output logic signed [31:0]   out_y,
    output logic signed [31:0]   out_z,
    output logic signed [31:0]   out_w,
    output logic                 saturated,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    logic [63:0] mat_reg [NUM_PAIRS];

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic ov_reg, ov_next;

    logic      load_out;
    logic      free1, free2, free3;
    pipe_ctl_t ctl;

    vec4_t                   vec;
    vec4_t                   row_entries [NUM_LANES];
    logic signed [SUM_W-1:0] lane_sum [NUM_LANES];
    vec4_t                   result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_PAIRS; k++)
            begin
                mat_reg[k] <= 64'd0;
            end
            mat_reg[0] <= 64'h0000_0000_0001_0000;
            mat_reg[2] <= 64'h0001_0000_0000_0000;
            mat_reg[5] <= 64'h0000_0000_0001_0000;
            mat_reg[7] <= 64'h0001_0000_0000_0000;
        end
        else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_PAIRS))
        begin
            mat_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Effective w follows the mode; the unused code behaves as a full vector.
    always_comb
    begin
        vec[0] = in_x;
        vec[1] = in_y;
        vec[2] = in_z;
        case (cmd)
            CMD_DIR:   vec[3] = 32'd0;
            CMD_POINT: vec[3] = 32'(1) << FRAC_BITS;
            default:   vec[3] = in_w;
        endcase
    end

    // Column-major storage: row r, column c sits in pair 2c + r/2, half r%2.
    always_comb
    begin
        for (int r = 0; r < NUM_LANES; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (r % 2 == 1)
                begin
                    row_entries[r][c] = mat_reg[2 * c + r / 2][63:32];
                end
                else
                begin
                    row_entries[r][c] = mat_reg[2 * c + r / 2][31:0];
                end
            end
        end
    end

    // Each stage loads when its successor is empty or moving on.
    always_comb
    begin
        load_out  = v3_reg && (!ov_reg || out_ready);
        free3     = !v3_reg || load_out;
        ctl.load3 = v2_reg && free3;
        free2     = !v2_reg || ctl.load3;
        ctl.load2 = v1_reg && free2;
        free1     = !v1_reg || ctl.load2;
        ctl.load1 = in_valid && free1;

        v1_next = ctl.load1 || (v1_reg && !ctl.load2);
        v2_next = ctl.load2 || (v2_reg && !ctl.load3);
        v3_next = ctl.load3 || (v3_reg && !load_out);
        ov_next = load_out || (ov_reg && !out_ready);
    end

    assign in_ready = free1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            ov_reg <= ov_next;
        end
    end

    for (genvar r = 0; r < NUM_LANES; r++)
    begin : g_lane
        vt4_lane u_lane (
            .clk         (clk),
            .ctl         (ctl),
            .row_entries (row_entries[r]),
            .vec         (vec),
            .sum         (lane_sum[r])
        );
    end

    vt4_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk       (clk),
        .load      (load_out),
        .lane_sum  (lane_sum),
        .result    (result),
        .saturated (saturated)
    );

    assign out_valid = ov_reg;
    assign out_x     = result[0];
    assign out_y     = result[1];
    assign out_z     = result[2];
    assign out_w     = result[3];

    // Input back-pressure only appears with every stage full and the output stalled.
    `VT4_ASSERT(a_full_when_blocked, clk, rst_n, !in_ready |-> (v1_reg && v2_reg && v3_reg && ov_reg && !out_ready))
    `VT4_NEVER(a_load_out_empty, clk, rst_n, load_out && !v3_reg)
    `VT4_ASSERT(a_stage3_from_stage2, clk, rst_n, $rose(v3_reg) |-> $past(v2_reg))

endmodule
